// File: rtl/gpio_prb_pkg.sv
`default_nettype none

package gpio_prb_pkg;

    localparam int NUM_PORTS_DEF = 15;
    localparam int NUM_LEDS_DEF  = 3;
    localparam int PINS_PER_PORT = 16;
    localparam int MAX_LEDS      = 8;
    localparam int HALF_W        = 16;

    localparam logic [1:0] MODE_READ   = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_INJECT = 2'd2;

    localparam logic [4:0] REG_CTRL   = 5'h00;
    localparam logic [4:0] REG_PINS   = 5'h04;
    localparam logic [4:0] REG_SETCLR = 5'h08;

    localparam logic [4:0] NO_PORT = 5'h1F;

    localparam logic [4:0] LED_PORT [MAX_LEDS] = '{
        5'd6, 5'd3, 5'd10, NO_PORT, NO_PORT, NO_PORT, NO_PORT, NO_PORT
    };
    localparam logic [3:0] LED_PIN [MAX_LEDS] = '{
        4'd0, 4'd3, 4'd7, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
    };

    typedef struct packed {
        logic [1:0]  mode;
        logic [8:0]  reg_offset;
        logic [31:0] write_data;
        logic [3:0]  pin_port;
        logic [3:0]  pin_index;
        logic        inject_level;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  led_levels;
        logic [31:0] led0_edges;
        logic [31:0] led1_edges;
        logic [31:0] led2_edges;
        logic        pin_level;
    } rsp_t;

    typedef struct packed {
        logic [HALF_W-1:0] direction;
        logic [HALF_W-1:0] out_latch;
        logic [HALF_W-1:0] input_override;
        logic [HALF_W-1:0] input_level;
    } entry_t;

    function automatic entry_t reset_entry(logic [3:0] port);
        entry_t e;
        e = '0;
        if (port == 4'd0)
        begin
            e.input_override = 16'h0300;
            e.input_level    = 16'h0300;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// File: rtl/gpio_prb_chan_if.sv
`default_nettype none

interface gpio_prb_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/gpio_port_register_bank_unit.sv
// GPIO port register bank: NUM_PORTS ports of 16 pins, each port keeping direction, output
// latch, input override mask and injected input level in one entry of a dual-read RAM.
// Each request is a bus read, a bus write, or a pin level injection, and yields exactly one
// response carrying read data, the board LED levels and edge counts, and the injected level
// at the named pin. A request passes through a registered RAM read of the bus port and pin port
// entries, then a modify step that writes back and loads the response register. A new
// request is taken while the previous response waits; the modify cycle stalls while the
// response register is still full. Entries come out of reset through per-port valid bits,
// so there is no clearing pass and the block takes requests right after reset.
`default_nettype none

module gpio_port_register_bank_unit
    import gpio_prb_pkg::*;
#(
    parameter int NUM_PORTS = NUM_PORTS_DEF,
    parameter int NUM_LEDS  = NUM_LEDS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    gpio_prb_chan_if.sink   req,
    gpio_prb_chan_if.source rsp
);

    localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int EW = $bits(entry_t);

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t               state_reg;
    req_t                 req_reg;
    rsp_t                 rsp_reg;
    logic                 rsp_valid_reg;
    logic [NUM_PORTS-1:0] valid_reg;
    logic                 led_lvl_reg  [NUM_LEDS];
    logic [31:0]          led_cnt_reg  [NUM_LEDS];
    logic                 led_lvl_next [NUM_LEDS];
    logic [31:0]          led_cnt_next [NUM_LEDS];

    logic          req_fire;
    logic          done;
    logic [3:0]    in_port;
    logic [EW-1:0] rdata_a;
    logic [EW-1:0] rdata_b;

    logic [3:0]    bus_port;
    logic [4:0]    regsel;
    logic [3:0]    pport;
    logic [3:0]    ppin;
    logic          port_ok;
    logic          pin_ok;
    entry_t        ent_a;
    entry_t        ent_b;
    entry_t        wr_ent;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          latch_wr;
    logic [31:0]   rd;
    logic          pin_lvl;
    logic [2:0]    led_view;
    logic [31:0]   cnt_view [3];
    rsp_t          rsp_next;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign done      = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp.ready);
    assign in_port   = req.data.reg_offset[8:5];

    gpio_prb_ram #(
        .WIDTH  (EW),
        .DEPTH  (NUM_PORTS),
        .ADDR_W (AW)
    ) u_ram (
        .clk     (clk),
        .we      (done && wr_en),
        .waddr   (wr_addr),
        .wdata   (wr_ent),
        .re      (req_fire),
        .raddr_a (in_port[AW-1:0]),
        .raddr_b (req.data.pin_port[AW-1:0]),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req.data;
        end
    end

    always_comb
    begin
        bus_port = req_reg.reg_offset[8:5];
        regsel   = req_reg.reg_offset[4:0];
        pport    = req_reg.pin_port;
        ppin     = req_reg.pin_index;
        port_ok  = {1'b0, bus_port} < 5'(NUM_PORTS);
        pin_ok   = ({1'b0, pport} < 5'(NUM_PORTS)) && ({1'b0, ppin} < 5'(PINS_PER_PORT));

        ent_a = (port_ok && valid_reg[bus_port[AW-1:0]]) ? entry_t'(rdata_a)
                                                         : reset_entry(bus_port);
        ent_b = (pin_ok && valid_reg[pport[AW-1:0]]) ? entry_t'(rdata_b)
                                                     : reset_entry(pport);

        wr_ent   = ent_a;
        wr_en    = 1'b0;
        wr_addr  = bus_port[AW-1:0];
        latch_wr = 1'b0;
        rd       = '0;

        unique case (req_reg.mode)
            MODE_READ:
            begin
                if (port_ok)
                begin
                    unique case (regsel)
                        REG_CTRL: rd = {ent_a.out_latch, ent_a.direction};
                        REG_PINS: rd = {16'h0000,
                                        (ent_a.out_latch & ent_a.direction)
                                        | (~ent_a.direction & ent_a.input_override
                                           & ent_a.input_level)};
                        default:  rd = '0;
                    endcase
                end
            end
            MODE_WRITE:
            begin
                if (port_ok)
                begin
                    unique case (regsel)
                        REG_CTRL:
                        begin
                            wr_ent.direction = req_reg.write_data[15:0];
                            wr_ent.out_latch = req_reg.write_data[31:16];
                            wr_en            = 1'b1;
                            latch_wr         = 1'b1;
                        end
                        REG_SETCLR:
                        begin
                            wr_ent.out_latch = (ent_a.out_latch | req_reg.write_data[15:0])
                                               & ~req_reg.write_data[31:16];
                            wr_en            = 1'b1;
                            latch_wr         = 1'b1;
                        end
                        default: wr_en = 1'b0;
                    endcase
                end
            end
            MODE_INJECT:
            begin
                if (pin_ok)
                begin
                    wr_ent                       = ent_b;
                    wr_ent.input_override[ppin]  = 1'b1;
                    wr_ent.input_level[ppin]     = req_reg.inject_level;
                    wr_addr                      = pport[AW-1:0];
                    wr_en                        = 1'b1;
                end
            end
            default: wr_en = 1'b0;
        endcase

        if (!pin_ok)
        begin
            pin_lvl = 1'b0;
        end
        else if (req_reg.mode == MODE_INJECT)
        begin
            pin_lvl = req_reg.inject_level;
        end
        else
        begin
            pin_lvl = ent_b.input_level[ppin];
        end

        for (int i = 0; i < NUM_LEDS; i++)
        begin
            led_lvl_next[i] = led_lvl_reg[i];
            led_cnt_next[i] = led_cnt_reg[i];
            if (latch_wr && (LED_PORT[i] == {1'b0, bus_port})
                && (ent_a.out_latch[LED_PIN[i]] != wr_ent.out_latch[LED_PIN[i]]))
            begin
                led_lvl_next[i] = wr_ent.out_latch[LED_PIN[i]];
                if (led_cnt_reg[i] != '1)
                begin
                    led_cnt_next[i] = led_cnt_reg[i] + 32'd1;
                end
            end
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_view
        if (g < NUM_LEDS)
        begin : g_on
            assign led_view[g] = led_lvl_next[g];
            assign cnt_view[g] = led_cnt_next[g];
        end
        else
        begin : g_off
            assign led_view[g] = 1'b0;
            assign cnt_view[g] = '0;
        end
    end

    always_comb
    begin
        rsp_next.read_data  = rd;
        rsp_next.led_levels = led_view;
        rsp_next.led0_edges = cnt_view[0];
        rsp_next.led1_edges = cnt_view[1];
        rsp_next.led2_edges = cnt_view[2];
        rsp_next.pin_level  = pin_lvl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        state_reg <= ST_EXEC;
                    end
                    if (rsp_valid_reg && rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b0;
                    end
                end
                ST_EXEC:
                begin
                    if (done)
                    begin
                        rsp_reg       <= rsp_next;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                led_lvl_reg[i] <= 1'b0;
                led_cnt_reg[i] <= '0;
            end
        end
        else if (done)
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                led_lvl_reg[i] <= led_lvl_next[i];
                led_cnt_reg[i] <= led_cnt_next[i];
            end
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

endmodule

`default_nettype wire

// File: rtl/gpio_prb_ram.sv
`default_nettype none

module gpio_prb_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 15,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [WIDTH-1:0]  rdata_a,
    output logic      [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

// File: tb/sv/tb_gpio_port_register_bank_unit.sv
`default_nettype none

module tb_gpio_port_register_bank_unit;
    import gpio_prb_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int RANDOM_ITEMS = 1700;
    localparam int TAIL_ITEMS   = 150;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 80;
    localparam int WATCHDOG_MAX = 4000;

    logic clk = 1'b0;
    logic rst_n;

    gpio_prb_chan_if #(.payload_t(req_t)) req_ch ();
    gpio_prb_chan_if #(.payload_t(rsp_t)) rsp_ch ();

    gpio_port_register_bank_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [15:0] m_dir   [NUM_PORTS_DEF];
    logic [15:0] m_latch [NUM_PORTS_DEF];
    logic [15:0] m_ovr   [NUM_PORTS_DEF];
    logic [15:0] m_lvl   [NUM_PORTS_DEF];
    logic        m_led_on  [NUM_LEDS_DEF];
    logic [31:0] m_led_cnt [NUM_LEDS_DEF];

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];

    int   errors = 0;
    int   total_items = 0;
    int   sent_count = 0;
    int   got_count = 0;
    int   send_gap = 0;
    int   recv_stall = 0;
    int   hold_cnt = 0;
    bit   hold_done = 1'b0;
    int   quiet_cycles = 0;
    rsp_t want;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void update_latch(int port, logic [15:0] next);
        logic was;
        logic now;
        for (int i = 0; i < NUM_LEDS_DEF; i++)
        begin
            if (int'(LED_PORT[i]) == port)
            begin
                was = m_latch[port][LED_PIN[i]];
                now = next[LED_PIN[i]];
                if (was != now)
                begin
                    m_led_on[i] = now;
                    if (m_led_cnt[i] != 32'hFFFF_FFFF)
                        m_led_cnt[i] = m_led_cnt[i] + 1;
                end
            end
        end
        m_latch[port] = next;
    endfunction

    function automatic rsp_t gpio_predict(req_t r);
        rsp_t        o;
        int          port;
        logic [4:0]  rg;
        logic [15:0] v;
        logic        pin_ok;
        o = '0;
        port = int'(r.reg_offset[8:5]);
        rg = r.reg_offset[4:0];
        pin_ok = (int'(r.pin_port) < NUM_PORTS_DEF) && (int'(r.pin_index) < PINS_PER_PORT);
        if (r.mode == MODE_READ && port < NUM_PORTS_DEF)
        begin
            if (rg == REG_CTRL)
                o.read_data = {m_latch[port], m_dir[port]};
            else if (rg == REG_PINS)
                o.read_data = {16'h0000, (m_latch[port] & m_dir[port])
                                         | (~m_dir[port] & m_ovr[port] & m_lvl[port])};
        end
        else if (r.mode == MODE_WRITE && port < NUM_PORTS_DEF)
        begin
            if (rg == REG_CTRL)
            begin
                m_dir[port] = r.write_data[15:0];
                update_latch(port, r.write_data[31:16]);
            end
            else if (rg == REG_SETCLR)
            begin
                v = m_latch[port] | r.write_data[15:0];
                v = v & ~r.write_data[31:16];
                update_latch(port, v);
            end
        end
        else if (r.mode == MODE_INJECT && pin_ok)
        begin
            m_ovr[r.pin_port][r.pin_index] = 1'b1;
            m_lvl[r.pin_port][r.pin_index] = r.inject_level;
        end
        o.led_levels = {m_led_on[2], m_led_on[1], m_led_on[0]};
        o.led0_edges = m_led_cnt[0];
        o.led1_edges = m_led_cnt[1];
        o.led2_edges = m_led_cnt[2];
        o.pin_level  = pin_ok ? m_lvl[r.pin_port][r.pin_index] : 1'b0;
        return o;
    endfunction

    function automatic void push_req(logic [1:0] mode, logic [8:0] offset, logic [31:0] wdata,
                                     logic [3:0] pport, logic [3:0] pidx, logic lvl);
        req_t r;
        r.mode         = mode;
        r.reg_offset   = offset;
        r.write_data   = wdata;
        r.pin_port     = pport;
        r.pin_index    = pidx;
        r.inject_level = lvl;
        pending_reqs.push_back(r);
    endfunction

    function automatic req_t random_req();
        req_t       r;
        int         k;
        logic [3:0] port;
        logic [4:0] rg;
        k = $urandom_range(0, 99);
        if (k < 35)
            r.mode = MODE_READ;
        else if (k < 70)
            r.mode = MODE_WRITE;
        else if (k < 95)
            r.mode = MODE_INJECT;
        else
            r.mode = MODE_NONE;
        if ($urandom_range(0, 4) == 0)
            r.reg_offset = 9'($urandom_range(0, 511));
        else
        begin
            k = $urandom_range(0, 2);
            if ($urandom_range(0, 2) == 0)
                port = (k == 0) ? 4'd6 : (k == 1) ? 4'd3 : 4'd10;
            else
                port = 4'($urandom_range(0, NUM_PORTS_DEF - 1));
            k = $urandom_range(0, 2);
            rg = (k == 0) ? REG_CTRL : (k == 1) ? REG_PINS : REG_SETCLR;
            r.reg_offset = {port, rg};
        end
        r.write_data   = $urandom;
        r.pin_port     = 4'($urandom_range(0, 15));
        r.pin_index    = 4'($urandom_range(0, 15));
        r.inject_level = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %h actual %h", $time, fname, want_v, got_v);
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
            send_gap     <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_rsps.push_back(gpio_predict(req_ch.data));
                sent_count++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap     <= send_gap - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0)
                    req_ch.valid <= 1'b0;
                else if (hold_cnt == 0 && sent_count < total_items - TAIL_ITEMS
                         && ((sent_count >> 7) % 3) != 1 && $urandom_range(0, 7) == 0)
                begin
                    send_gap     <= $urandom_range(0, 7);
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.data  <= pending_reqs.pop_front();
                end
            end
        end
    end

    // response monitor and receiver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_stall   <= 0;
            hold_cnt     <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got_count++;
                if (expected_rsps.size() == 0)
                begin
                    errors++;
                    $display("%0t: response with no request pending: actual %h",
                             $time, rsp_ch.data);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    check_field("read_data", want.read_data, rsp_ch.data.read_data);
                    check_field("led_levels", 32'(want.led_levels), 32'(rsp_ch.data.led_levels));
                    check_field("led0_edges", want.led0_edges, rsp_ch.data.led0_edges);
                    check_field("led1_edges", want.led1_edges, rsp_ch.data.led1_edges);
                    check_field("led2_edges", want.led2_edges, rsp_ch.data.led2_edges);
                    check_field("pin_level", 32'(want.pin_level), 32'(rsp_ch.data.pin_level));
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt     <= hold_cnt - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (!hold_done && got_count >= HOLD_AT)
            begin
                hold_done    <= 1'b1;
                hold_cnt     <= HOLD_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall   <= recv_stall - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (got_count < total_items - TAIL_ITEMS && ((got_count >> 6) % 3) != 2
                     && $urandom_range(0, 7) == 0)
            begin
                recv_stall   <= $urandom_range(0, 7);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("tb_gpio_port_register_bank_unit: FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        for (int p = 0; p < NUM_PORTS_DEF; p++)
        begin
            m_dir[p]   = 16'h0000;
            m_latch[p] = 16'h0000;
            m_ovr[p]   = 16'h0000;
            m_lvl[p]   = 16'h0000;
        end
        m_ovr[0] = 16'h0300;
        m_lvl[0] = 16'h0300;
        for (int i = 0; i < NUM_LEDS_DEF; i++)
        begin
            m_led_on[i]  = 1'b0;
            m_led_cnt[i] = 32'h0;
        end

        push_req(MODE_READ,   9'd0,   32'h0,         4'd0,  4'd8,  1'b0);
        push_req(MODE_READ,   9'd4,   32'h0,         4'd0,  4'd9,  1'b0);
        push_req(MODE_WRITE,  9'd192, 32'h0001_FFFF, 4'd6,  4'd0,  1'b0);
        push_req(MODE_READ,   9'd196, 32'h0,         4'd6,  4'd0,  1'b0);
        push_req(MODE_WRITE,  9'd200, 32'h0001_0001, 4'd6,  4'd0,  1'b0);
        push_req(MODE_WRITE,  9'd96,  32'hFFFF_0000, 4'd3,  4'd3,  1'b1);
        push_req(MODE_READ,   9'd100, 32'h0,         4'd3,  4'd3,  1'b0);
        push_req(MODE_WRITE,  9'd328, 32'h0000_0080, 4'd10, 4'd7,  1'b0);
        push_req(MODE_WRITE,  9'd328, 32'h0080_0000, 4'd10, 4'd7,  1'b0);
        push_req(MODE_INJECT, 9'd0,   32'h0,         4'd14, 4'd15, 1'b1);
        push_req(MODE_READ,   9'd452, 32'h0,         4'd14, 4'd15, 1'b0);
        push_req(MODE_INJECT, 9'd0,   32'h0,         4'd14, 4'd15, 1'b0);
        push_req(MODE_INJECT, 9'd0,   32'h0,         4'd15, 4'd3,  1'b1);
        push_req(MODE_READ,   9'd480, 32'h0,         4'd15, 4'd3,  1'b0);
        push_req(MODE_WRITE,  9'd480, 32'hFFFF_FFFF, 4'd0,  4'd0,  1'b0);
        push_req(MODE_READ,   9'd511, 32'h0,         4'd0,  4'd0,  1'b0);
        push_req(MODE_READ,   9'd1,   32'h0,         4'd0,  4'd0,  1'b0);
        push_req(MODE_READ,   9'd8,   32'h0,         4'd0,  4'd0,  1'b0);
        push_req(MODE_WRITE,  9'd31,  32'hFFFF_FFFF, 4'd0,  4'd0,  1'b0);
        push_req(MODE_NONE,   9'd0,   32'hFFFF_FFFF, 4'd0,  4'd0,  1'b1);
        push_req(MODE_INJECT, 9'd0,   32'h0,         4'd0,  4'd0,  1'b1);
        push_req(MODE_READ,   9'd4,   32'h0,         4'd0,  4'd0,  1'b0);
        push_req(MODE_WRITE,  9'd64,  32'hFFFF_FFFF, 4'd2,  4'd0,  1'b0);
        push_req(MODE_READ,   9'd64,  32'h0,         4'd2,  4'd0,  1'b0);
        push_req(MODE_READ,   9'd68,  32'h0,         4'd2,  4'd0,  1'b0);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            pending_reqs.push_back(random_req());
        total_items = pending_reqs.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb_gpio_port_register_bank_unit: PASS");
        else
            $display("tb_gpio_port_register_bank_unit: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/gpio_prb_pkg.sv
rtl/gpio_prb_chan_if.sv
rtl/gpio_prb_ram.sv
rtl/gpio_port_register_bank_unit.sv
tb/sv/tb_gpio_port_register_bank_unit.sv
